// ----- rtl/gbte_pkg.sv -----
// ----------------------------------------------------------------------------
// gbte_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package gbte_pkg;

	localparam int LEN_W        = 13;
	localparam int CAPACITY_DEF = 4096;
	localparam int ROUND_STEP   = 4 << 10;
	localparam int ROUND_SH     = $clog2(ROUND_STEP);
	localparam int REQ_W        = 15;
	localparam int SHIFT_W      = 14;
	localparam int S_TDATA_W    = 64;
	localparam int M_TDATA_W    = 56;
	localparam int TUSER_W      = 2;
	localparam int PADDR_W      = 3;
	localparam int PDATA_W      = 32;

	// register index of buffer_limit
	localparam int REG_BUFFER_LIMIT = 0;

	typedef enum logic [1:0] {
		REQ_REPLACE = 2'd0,
		REQ_DATA    = 2'd1,
		REQ_READ    = 2'd2
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_ROOM = 2'd1,
		ST_BAD     = 2'd2,
		ST_ORDER   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_MOVE,
		S_READ
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic move_run;
		logic read_out;
	} dp_cmd_t;

	typedef struct packed {
		logic need_move;
		logic need_read;
		logic move_busy;
	} dp_stat_t;

endpackage

// ----- rtl/gbte_ctrl.sv -----
// ----------------------------------------------------------------------------
// gbte_ctrl
// sequencer: takes a beat, executes it, runs the gap move or the store read,
// and owns the valid flag of the output register
// ----------------------------------------------------------------------------
module gbte_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output gbte_pkg::dp_cmd_t  cmd,
	input  gbte_pkg::dp_stat_t stat
);
	import gbte_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_free;
	logic        out_set;

	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		out_set  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
				if (s_tvalid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					cmd.exec = 1'b1;
					if (stat.need_move) begin
						out_set = 1'b1;
						state_d = S_MOVE;
					end else if (stat.need_read) begin
						state_d = S_READ;
					end else begin
						out_set = 1'b1;
						state_d = S_IDLE;
					end
				end
			end
			S_MOVE: begin
				cmd.move_run = 1'b1;
				if (!stat.move_busy) begin
					state_d = S_IDLE;
				end
			end
			S_READ: begin
				cmd.read_out = 1'b1;
				out_set      = 1'b1;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_set) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// the store read result always finds the output register free
	a_read_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |-> !out_valid_q)
		else $error("read result would overwrite a pending beat");

	// a move is only started together with its result beat
	a_move_entry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC && state_d == S_MOVE |=> out_valid_q)
		else $error("move started without result beat");

endmodule

// ----- rtl/gbte_dp.sv -----
// ----------------------------------------------------------------------------
// gbte_dp
// datapath: text store, front/gap/back lengths, range checks, gap-move
// copy engine and output register payload
// ----------------------------------------------------------------------------
module gbte_dp #(
	parameter int CAPACITY = gbte_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gbte_pkg::dp_cmd_t             cmd,
	output gbte_pkg::dp_stat_t            stat,
	input  logic [1:0]                    req_type,
	input  logic [gbte_pkg::LEN_W-1:0]    start_req,
	input  logic [gbte_pkg::LEN_W-1:0]    end_pos,
	input  logic [gbte_pkg::LEN_W-1:0]    length,
	input  logic [7:0]                    data_byte,
	input  logic [11:0]                   position,
	input  logic                          cfg_we,
	input  logic [gbte_pkg::LEN_W-1:0]    cfg_wdata,
	output logic [gbte_pkg::LEN_W-1:0]    limit,
	output logic [1:0]                    status,
	output logic [7:0]                    read_byte,
	output logic [gbte_pkg::SHIFT_W-1:0]  size_delta,
	output logic [gbte_pkg::REQ_W-1:0]    grow_bytes,
	output logic [gbte_pkg::LEN_W-1:0]    text_size
);
	import gbte_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int IW = (AW + 1 > LEN_W + 1) ? AW + 1 : LEN_W + 1;
	localparam int NW = LEN_W + 2;
	localparam logic [IW-1:0] CAP_I = IW'(CAPACITY);
	localparam logic [LEN_W-1:0] LIMIT_RST = (CAPACITY < 4096) ?
		LEN_W'(CAPACITY) : LEN_W'(4096);

	logic [7:0] mem [CAPACITY];
	logic [7:0] rdata_q;

	// captured beat
	req_type_t        type_q;
	logic [LEN_W-1:0] start_q, end_q, len_q;
	logic [7:0]       byte_q;
	logic [11:0]      pos_q;

	// text state
	logic [LEN_W-1:0] limit_q, front_q, gap_q, back_q, exp_q;

	// move engine
	logic [LEN_W-1:0] cnt_q;
	logic             wr_pend_q, down_q;
	logic [AW-1:0]    rd_ptr_q, wr_ptr_q;

	// checks
	logic [LEN_W-1:0] size, repl, back_new;
	logic [NW-1:0]    new_size;
	logic [NW+1:0]    want_sum;
	logic             bad_rng, no_room, mv_down, mv_up, repl_ok;
	logic             data_ok, rd_bad, rd_oob;
	logic [IW-1:0]    pos_i, idx;
	logic [IW-1:0]    cfg_i, cfg_clamp;

	// result of the executed beat
	status_t              res_status;
	logic [SHIFT_W-1:0]   res_shift;
	logic [REQ_W-1:0]     res_req;
	logic [LEN_W-1:0]     res_size;

	// memory port selection
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_wdata;

	assign limit    = limit_q;
	assign size     = LEN_W'(front_q + back_q);
	assign repl     = end_q - start_q;
	assign back_new = size - end_q;
	assign new_size = NW'(size) - NW'(repl) + NW'(len_q);
	assign want_sum = {1'b0, new_size, 1'b0} + (NW+2)'(ROUND_STEP - 1);
	assign bad_rng  = (start_q > end_q) || (end_q > size);
	assign no_room  = new_size > NW'(limit_q);
	assign mv_down  = end_q < front_q;
	assign mv_up    = start_q > front_q;
	assign repl_ok  = (exp_q == '0) && !bad_rng && !no_room;
	assign data_ok  = (exp_q != '0) && (gap_q != '0) && (IW'(front_q) < CAP_I);
	assign pos_i    = IW'(pos_q);
	assign rd_bad   = {1'b0, pos_q} >= size;
	assign idx      = (pos_i < IW'(front_q)) ? pos_i : pos_i + IW'(gap_q);
	assign rd_oob   = idx >= CAP_I;
	assign cfg_i    = (cfg_wdata == '0) ? IW'(1) : IW'(cfg_wdata);
	assign cfg_clamp = (cfg_i > CAP_I) ? CAP_I : cfg_i;

	assign stat.need_move = (type_q == REQ_REPLACE) && repl_ok && (mv_down || mv_up);
	assign stat.need_read = (type_q == REQ_READ) && !rd_bad && !rd_oob;
	assign stat.move_busy = (cnt_q != '0) || wr_pend_q;

	always_comb begin
		res_status = ST_OK;
		res_shift  = '0;
		res_req    = '0;
		res_size   = size;
		case (type_q)
			REQ_REPLACE: begin
				if (exp_q != '0) begin
					res_status = ST_ORDER;
				end else if (bad_rng) begin
					res_status = ST_BAD;
				end else begin
					res_shift = SHIFT_W'(len_q) - SHIFT_W'(repl);
					if (no_room) begin
						res_status = ST_NO_ROOM;
						res_req    = REQ_W'({want_sum[NW+1:ROUND_SH], ROUND_SH'(0)});
					end else begin
						res_size = start_q + back_new;
					end
				end
			end
			REQ_DATA: begin
				if (data_ok) begin
					res_size = size + LEN_W'(1);
				end else begin
					res_status = ST_ORDER;
				end
			end
			REQ_READ: begin
				if (rd_bad || rd_oob) begin
					res_status = ST_BAD;
				end
			end
			default: begin
				res_status = ST_BAD;
			end
		endcase
	end

	// capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			type_q  <= req_type_t'(req_type);
			start_q <= start_req;
			end_q   <= end_pos;
			len_q   <= length;
			byte_q  <= data_byte;
			pos_q   <= position;
		end
	end

	// text state and limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RST;
			front_q <= '0;
			gap_q   <= LIMIT_RST;
			back_q  <= '0;
			exp_q   <= '0;
		end else if (cmd.exec) begin
			if (type_q == REQ_REPLACE && repl_ok) begin
				front_q <= start_q;
				back_q  <= back_new;
				gap_q   <= limit_q - start_q - back_new;
				exp_q   <= len_q;
			end else if (type_q == REQ_DATA && data_ok) begin
				front_q <= front_q + LEN_W'(1);
				gap_q   <= gap_q - LEN_W'(1);
				exp_q   <= exp_q - LEN_W'(1);
			end
		end else if (cfg_we && size == '0 && exp_q == '0) begin
			limit_q <= cfg_clamp[LEN_W-1:0];
			gap_q   <= cfg_clamp[LEN_W-1:0];
		end
	end

	// gap move engine: read one byte a cycle, write it in the cycle after
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			wr_pend_q <= 1'b0;
		end else if (cmd.exec && stat.need_move) begin
			cnt_q     <= mv_down ? (front_q - end_q) : (start_q - front_q);
			wr_pend_q <= 1'b0;
		end else if (cmd.move_run) begin
			wr_pend_q <= cnt_q != '0;
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - LEN_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && stat.need_move) begin
			down_q <= mv_down;
			if (mv_down) begin
				rd_ptr_q <= AW'(IW'(front_q) - IW'(1));
				wr_ptr_q <= AW'(IW'(front_q) + IW'(gap_q) - IW'(1));
			end else begin
				rd_ptr_q <= AW'(IW'(front_q) + IW'(gap_q));
				wr_ptr_q <= AW'(front_q);
			end
		end else if (cmd.move_run) begin
			if (cnt_q != '0) begin
				rd_ptr_q <= down_q ? rd_ptr_q - AW'(1) : rd_ptr_q + AW'(1);
			end
			if (wr_pend_q) begin
				wr_ptr_q <= down_q ? wr_ptr_q - AW'(1) : wr_ptr_q + AW'(1);
			end
		end
	end

	// text store
	assign mem_we    = (cmd.exec && type_q == REQ_DATA && data_ok) ||
		(cmd.move_run && wr_pend_q);
	assign mem_waddr = cmd.move_run ? wr_ptr_q : AW'(front_q);
	assign mem_wdata = cmd.move_run ? rdata_q : byte_q;
	assign mem_raddr = cmd.move_run ? rd_ptr_q : idx[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.read_out) begin
			status     <= ST_OK;
			read_byte  <= rdata_q;
			size_delta <= '0;
			grow_bytes <= '0;
			text_size  <= size;
		end else if (cmd.exec && !stat.need_read) begin
			status     <= res_status;
			read_byte  <= '0;
			size_delta <= res_shift;
			grow_bytes <= res_req;
			text_size  <= res_size;
		end
	end

	// front, gap and back always tile the usable capacity
	a_tiling: assert property (@(posedge clk) disable iff (!arst_n)
		NW'(front_q) + NW'(gap_q) + NW'(back_q) == NW'(limit_q))
		else $error("front, gap and back do not add up to the limit");

	// pending data bytes always fit in the gap
	a_pending_fit: assert property (@(posedge clk) disable iff (!arst_n)
		exp_q <= gap_q)
		else $error("pending bytes exceed gap");

	// each move cycle copies exactly one byte
	a_move_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.move_run && cnt_q != '0 |=> wr_pend_q && cnt_q == $past(cnt_q) - LEN_W'(1))
		else $error("move counter out of step");

endmodule

// ----- rtl/gap_buffer_text_engine.sv -----
// ----------------------------------------------------------------------------
// gap_buffer_text_engine
// gap-buffer text store with replace, insert-byte and read beats
// flow: an accepted beat is executed and its result registered for m_tvalid; a read
// first passes the store read state; no new beat is taken before the last is done,
// and a replace that moves bytes across the gap holds the input for the copy, one
// byte per cycle; a result beat not yet taken holds the next beat in execute
// reset: front/back/pending zero, gap and limit min(4096, CAPACITY); store not cleared
// ----------------------------------------------------------------------------
module gap_buffer_text_engine #(
	parameter int CAPACITY = gbte_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// slave beat
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// start_req[12:0], end_pos[25:13], length[38:26], data_byte[46:39],
	// position[58:47], zero fill
	input  logic [gbte_pkg::S_TDATA_W-1:0]    s_tdata,
	// req_type[1:0]
	input  logic [gbte_pkg::TUSER_W-1:0]      s_tuser,
	// master beat
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// read_byte[7:0], size_delta[21:8], grow_bytes[36:22],
	// text_size[49:37], zero fill
	output logic [gbte_pkg::M_TDATA_W-1:0]    m_tdata,
	// status[1:0]
	output logic [gbte_pkg::TUSER_W-1:0]      m_tuser,
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [gbte_pkg::PADDR_W-1:0]      paddr,
	input  logic [gbte_pkg::PDATA_W-1:0]      pwdata,
	output logic [gbte_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready
);
	import gbte_pkg::*;

	dp_cmd_t             cmd;
	dp_stat_t            stat;
	logic                reg_hit;
	logic                cfg_we;
	logic [LEN_W-1:0]    limit;
	logic [1:0]          status;
	logic [7:0]          read_byte;
	logic [SHIFT_W-1:0]  size_delta;
	logic [REQ_W-1:0]    grow_bytes;
	logic [LEN_W-1:0]    text_size;

	assign pready  = 1'b1;
	assign reg_hit = paddr[PADDR_W-1] == 1'(REG_BUFFER_LIMIT);
	assign cfg_we  = psel && penable && pwrite && pready && reg_hit;
	assign prdata  = reg_hit ? PDATA_W'(limit) : '0;

	gbte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	gbte_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.req_type   (s_tuser[1:0]),
		.start_req  (s_tdata[12:0]),
		.end_pos    (s_tdata[25:13]),
		.length     (s_tdata[38:26]),
		.data_byte  (s_tdata[46:39]),
		.position   (s_tdata[58:47]),
		.cfg_we     (cfg_we),
		.cfg_wdata  (pwdata[LEN_W-1:0]),
		.limit      (limit),
		.status     (status),
		.read_byte  (read_byte),
		.size_delta (size_delta),
		.grow_bytes (grow_bytes),
		.text_size  (text_size)
	);

	assign m_tuser = status;
	assign m_tdata = {6'b0, text_size, grow_bytes, size_delta, read_byte};

endmodule

// ----- bench/tb_gap_buffer_text_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gap_buffer_text_engine
// Self-checking bench for the gap-buffer text engine. A scoreboard class keeps
// its own copy of the text store, the front/gap/back split and the limit, and
// predicts the result beat for every accepted request. A directed opening
// covers the corner cases, then random phases at several buffer limits run
// edit sessions with random idling on both streams and one long output stall.
// ----------------------------------------------------------------------------
import gbte_pkg::*;

typedef struct packed {
	logic [1:0]         status;
	logic [7:0]         rd_byte;
	logic [SHIFT_W-1:0] shift;
	logic [REQ_W-1:0]   req_amount;
	logic [LEN_W-1:0]   txt_len;
} edit_result_t;

class gap_text_scoreboard;
	bit [7:0]     store [CAPACITY_DEF];
	int unsigned  limit;
	int unsigned  front;
	int unsigned  gap;
	int unsigned  back;
	int unsigned  pending;
	edit_result_t expected_beats[$];
	int           errors;
	int           checked;
	int           by_status [4];
	int           by_kind [4];

	function new();
		limit   = CAPACITY_DEF;
		front   = 0;
		gap     = CAPACITY_DEF;
		back    = 0;
		pending = 0;
		errors  = 0;
		checked = 0;
		foreach (by_status[i]) by_status[i] = 0;
		foreach (by_kind[i]) by_kind[i] = 0;
	endfunction

	function int unsigned text_len();
		return front + back;
	endfunction

	function void fail(string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endfunction

	function void write_limit(logic [PDATA_W-1:0] value);
		int unsigned v;
		if (front + back != 0 || pending != 0)
			return;
		v = value[LEN_W-1:0];
		if (v < 1)
			v = 1;
		if (v > CAPACITY_DEF)
			v = CAPACITY_DEF;
		limit = v;
		gap   = v;
	endfunction

	function void note_beat(logic [1:0] kind, logic [S_TDATA_W-1:0] d);
		int unsigned  s, e, l, p, sz, nsz, m, idx, want, tl;
		int           sh;
		edit_result_t r;
		s  = d[12:0];
		e  = d[25:13];
		l  = d[38:26];
		p  = d[58:47];
		sz = front + back;
		r  = '0;
		if (kind == REQ_REPLACE) begin
			if (pending != 0) begin
				r.status = ST_ORDER;
			end else if (s > e || e > sz) begin
				r.status = ST_BAD;
			end else begin
				sh = int'(l) - int'(e - s);
				r.shift = sh[SHIFT_W-1:0];
				nsz = sz - (e - s) + l;
				if (nsz > limit) begin
					want = ((2 * nsz + ROUND_STEP - 1) / ROUND_STEP) * ROUND_STEP;
					r.status = ST_NO_ROOM;
					r.req_amount = want[REQ_W-1:0];
				end else begin
					if (e < front) begin
						m = front - e;
						for (int i = int'(m) - 1; i >= 0; i--)
							store[front + gap - m + i] = store[e + i];
						front -= m;
						back += m;
					end
					if (s > front) begin
						m = s - front;
						for (int i = 0; i < int'(m); i++)
							store[front + i] = store[front + gap + i];
						front += m;
						back -= m;
					end
					front   = s;
					back    = sz - e;
					gap     = limit - front - back;
					pending = l;
					r.status = ST_OK;
				end
			end
		end else if (kind == REQ_DATA) begin
			if (pending == 0 || gap == 0 || front >= CAPACITY_DEF) begin
				r.status = ST_ORDER;
			end else begin
				store[front] = d[46:39];
				front++;
				gap--;
				pending--;
				r.status = ST_OK;
			end
		end else if (kind == REQ_READ) begin
			if (p >= sz) begin
				r.status = ST_BAD;
			end else begin
				idx = (p < front) ? p : p + gap;
				if (idx >= CAPACITY_DEF) begin
					r.status = ST_BAD;
				end else begin
					r.status  = ST_OK;
					r.rd_byte = store[idx];
				end
			end
		end else begin
			r.status = ST_BAD;
		end
		tl = front + back;
		r.txt_len = tl[LEN_W-1:0];
		by_status[r.status]++;
		by_kind[kind]++;
		expected_beats.push_back(r);
	endfunction

	function void check_beat(logic [1:0] st, logic [M_TDATA_W-1:0] d);
		edit_result_t want, got;
		got.status     = st;
		got.rd_byte    = d[7:0];
		got.shift      = d[21:8];
		got.req_amount = d[36:22];
		got.txt_len    = d[49:37];
		checked++;
		if (expected_beats.size() == 0) begin
			fail($sformatf("unexpected result beat: status %0d size %0d", st, got.txt_len));
			return;
		end
		want = expected_beats.pop_front();
		if (got !== want)
			fail($sformatf({"mismatch at beat %0d: exp status %0d byte %02h shift %0d ",
				"req %0d size %0d, got status %0d byte %02h shift %0d req %0d size %0d"},
				checked, want.status, want.rd_byte, $signed(want.shift), want.req_amount,
				want.txt_len, got.status, got.rd_byte, $signed(got.shift),
				got.req_amount, got.txt_len));
	endfunction
endclass

module tb_gap_buffer_text_engine;

	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [TUSER_W-1:0]   s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [TUSER_W-1:0]   m_tuser;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]   pwdata;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	gap_text_scoreboard sb;
	bit                 steady = 1'b0;
	int                 hold_left = 0;
	bit                 held = 1'b0;

	gap_buffer_text_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#(50_000_000);
		$display("simulation failed");
		$finish;
	end

	// result side: check, then decide next ready with one long hold-off
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_beat(m_tuser, m_tdata);
		if (hold_left > 0) begin
			hold_left--;
		end else if (!held && sb != null && sb.checked >= 120) begin
			hold_left = 300;
			held = 1'b1;
		end
		m_tready <= (hold_left == 0) && (steady || $urandom_range(0, 99) >= 25);
	end

	function automatic int unsigned rnd13();
		return $urandom_range(0, 4096);
	endfunction

	task automatic send_item(input logic [1:0] kind, input int unsigned s, e, l, b, p);
		logic [S_TDATA_W-1:0] d;
		d = '0;
		d[12:0]  = s[12:0];
		d[25:13] = e[12:0];
		d[38:26] = l[12:0];
		d[46:39] = b[7:0];
		d[58:47] = p[11:0];
		while (!steady && $urandom_range(0, 99) < 25) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= d;
		do @(posedge clk); while (!s_tready);
		sb.note_beat(kind, d);
	endtask

	task automatic replace_cmd(input int unsigned s, e, l);
		send_item(REQ_REPLACE, s, e, l, $urandom_range(0, 255), $urandom_range(0, 4095));
	endtask

	task automatic put_byte(input int unsigned b);
		send_item(REQ_DATA, rnd13(), rnd13(), rnd13(), b, $urandom_range(0, 4095));
	endtask

	task automatic read_at(input int unsigned p);
		send_item(REQ_READ, rnd13(), rnd13(), rnd13(), $urandom_range(0, 255), p);
	endtask

	task automatic send_unknown();
		send_item(REQ_UNKNOWN, rnd13(), rnd13(), rnd13(), $urandom_range(0, 255),
			$urandom_range(0, 4095));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.expected_beats.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_limit(input logic [PDATA_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(REG_BUFFER_LIMIT * 4);
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		sb.write_limit(v);
	endtask

	task automatic clear_text();
		while (sb.pending != 0)
			put_byte($urandom_range(0, 255));
		replace_cmd(0, sb.text_len(), 0);
		drain();
	endtask

	task automatic random_item();
		int unsigned sz, lim, r, s, e, l, room, cap;
		sz  = sb.text_len();
		lim = sb.limit;
		r   = $urandom_range(0, 99);
		e   = $urandom_range(0, sz);
		s   = $urandom_range(0, e);
		if (sb.pending != 0) begin
			if (r < 75)
				put_byte($urandom_range(0, 255));
			else if (r < 88)
				read_at(sz > 0 ? $urandom_range(0, sz - 1) : 0);
			else if (r < 92)
				read_at($urandom_range(0, 4095));
			else if (r < 97)
				replace_cmd(s, e, $urandom_range(0, 16));
			else
				send_unknown();
		end else begin
			room = lim - (sz - (e - s));
			cap  = (sz > 150) ? 4 : 16;
			if (r < 45) begin
				l = $urandom_range(0, room < cap ? room : cap);
				replace_cmd(s, e, l);
			end else if (r < 50 && room < 4096) begin
				replace_cmd(s, e, $urandom_range(room + 1, 4096));
			end else if (r < 80) begin
				read_at(sz > 0 ? $urandom_range(0, sz - 1) : $urandom_range(0, 4095));
			end else if (r < 88) begin
				read_at($urandom_range(0, 4095));
			end else if (r < 94 || r < 50) begin
				if ($urandom_range(0, 1) && sz < 4096) begin
					e = $urandom_range(sz + 1, 4096);
					s = $urandom_range(0, e);
				end else begin
					e = $urandom_range(0, 4095);
					s = $urandom_range(e + 1, 4096);
				end
				replace_cmd(s, e, rnd13());
			end else if (r < 97) begin
				put_byte($urandom_range(0, 255));
			end else begin
				send_unknown();
			end
		end
	endtask

	initial begin
		logic [PDATA_W-1:0] lim_val;
		sb = new();
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		m_tready <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner cases on an empty text, then a short edit session
		read_at(0);
		put_byte(8'h3C);
		send_unknown();
		replace_cmd(0, 1, 3);
		replace_cmd(1, 0, 0);
		replace_cmd(0, 0, 5);
		put_byte(8'h00);
		put_byte(8'hFF);
		read_at(1);
		replace_cmd(0, 0, 0);
		put_byte(8'hA5);
		put_byte(8'h5A);
		put_byte(8'h80);
		put_byte(8'h11);
		read_at(4);
		read_at(5);
		replace_cmd(1, 3, 1);
		put_byte(8'h7E);
		read_at(1);
		read_at(4095);
		replace_cmd(4, 4, 4096);
		replace_cmd(4096, 4096, 0);
		replace_cmd(0, 4, 0);
		drain();

		// limit clamps low, then a write with text present must be ignored
		set_limit(0);
		replace_cmd(0, 0, 1);
		put_byte(8'hC3);
		replace_cmd(1, 1, 1);
		drain();
		set_limit(4096);
		replace_cmd(0, 0, 1);
		clear_text();
		set_limit(8191);

		for (int ph = 0; ph < 5; ph++) begin
			clear_text();
			case (ph)
				0: lim_val = 4096;
				1: lim_val = 32'hABCD_0000 | $urandom_range(2, 24);
				2: lim_val = 1;
				3: lim_val = $urandom_range(25, 400);
				default: lim_val = 4096;
			endcase
			set_limit(lim_val);
			steady = (ph == 4);
			repeat (80) random_item();
		end
		steady = 1'b0;
		drain();

		if (sb.expected_beats.size() != 0)
			sb.fail($sformatf("%0d result beats never arrived", sb.expected_beats.size()));
		$display("%0d request beats: %0d applied, %0d no room, %0d rejected, %0d out of order",
			sb.checked, sb.by_status[ST_OK], sb.by_status[ST_NO_ROOM], sb.by_status[ST_BAD],
			sb.by_status[ST_ORDER]);
		$display("%0d replaces, %0d data bytes, %0d reads over limits from 1 to 4096",
			sb.by_kind[REQ_REPLACE], sb.by_kind[REQ_DATA], sb.by_kind[REQ_READ]);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
